/* rtl/kts_pkg.sv */
package kts_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_W    = 64;
  localparam int WEIGHT_W = 8;
  localparam int ACTION_W = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int BUDGET_W = 8;

  localparam logic [BUDGET_W-1:0] BUDGET_RST = 8'd16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OUT_RANGE = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } ctrl_state_t;

  // control from the sequencer to the ring of cells
  typedef struct packed {
    logic                shift;
    logic                load;
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
  } ring_ctrl_t;

endpackage

/* rtl/kts_cell.sv */
module kts_cell import kts_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [KEY_BITS-1:0] din_key,
  input  logic [WEIGHT_W-1:0] din_weight,
  output logic [KEY_BITS-1:0] key,
  output logic [WEIGHT_W-1:0] weight
);

  always_ff @(posedge clk) begin
    if (shift) begin
      key    <= din_key;
      weight <= din_weight;
    end
  end

endmodule

/* rtl/kts_ctrl.sv */
module kts_ctrl import kts_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    entry_key,
  input  logic [WEIGHT_W-1:0] entry_weight,
  input  logic [POS_W-1:0]    position,
  input  logic                cfg_valid,
  input  logic [BUDGET_W-1:0] cfg_data,
  input  logic [KEY_BITS-1:0] head_key,
  input  logic [WEIGHT_W-1:0] head_weight,
  output ring_ctrl_t          ring,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  found_index,
  output logic [KEY_W-1:0]    result_key,
  output logic [WEIGHT_W-1:0] result_weight,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [BUDGET_W-1:0] space_used
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = CNT_W + POS_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOTS - 1);

  ctrl_state_t state, state_next;

  logic [BUDGET_W-1:0] budget;
  logic [CNT_W-1:0]    count, count_next;
  logic [BUDGET_W-1:0] used, used_next;

  logic [ACTION_W-1:0] op;
  logic [KEY_BITS-1:0] key_r;
  logic [WEIGHT_W-1:0] wt_r;
  logic [IDX_W-1:0]    pos_r;
  logic                imm;
  logic [STATUS_W-1:0] imm_status;

  logic [IDX_W-1:0]    step;
  logic                found;
  logic [IDX_W-1:0]    match;
  logic [KEY_BITS-1:0] cap_key;
  logic [WEIGHT_W-1:0] cap_w;
  logic [KEY_BITS-1:0] last_key;
  logic [WEIGHT_W-1:0] last_w;

  logic                accept;
  logic                no_space;
  logic                read_ok;
  logic                in_range;
  logic                hit;
  logic                capture;
  logic                at_last;

  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic                res_slot;
  logic [KEY_BITS-1:0] res_key;
  logic [WEIGHT_W-1:0] res_w;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign no_space = ({1'b0, used} + {1'b0, entry_weight}) > {1'b0, budget};
  assign read_ok  = CMP_W'(position) < CMP_W'(count);

  assign in_range = CNT_W'(step) < count;
  assign hit      = (state == ST_SCAN) && in_range && !found && (head_key == key_r);
  assign capture  = (op == ACT_READ) ? ((state == ST_SCAN) && (step == pos_r)) : hit;
  assign at_last  = (state == ST_SCAN) && ((CNT_W'(step) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ring       = '0;
    res_status = STAT_OK;
    res_idx    = '0;
    res_slot   = 1'b0;
    res_key    = '0;
    res_w      = '0;
    count_next = count;
    used_next  = used;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_INSERT: state_next = no_space ? ST_DONE : ST_SCAN;
            ACT_ERASE,
            ACT_FIND:   state_next = ST_SCAN;
            ACT_READ:   state_next = read_ok ? ST_SCAN : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        ring.shift = 1'b1;
        // new entry drops into the slot just past the last valid one
        ring.load   = (op == ACT_INSERT) && !found && (CNT_W'(step) == count);
        ring.key    = KEY_W'(key_r);
        ring.weight = wt_r;
        if (step == LAST_STEP) begin
          state_next = ((op == ACT_ERASE) && (found || hit)) ? ST_MOVE : ST_DONE;
        end
      end
      ST_MOVE: begin
        ring.shift  = 1'b1;
        ring.load   = (step == match);
        ring.key    = KEY_W'(last_key);
        ring.weight = last_w;
        if (step == LAST_STEP) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
        if (imm) begin
          res_status = imm_status;
          if (op == ACT_CLEAR) begin
            count_next = '0;
            used_next  = '0;
          end
        end else begin
          unique case (op)
            ACT_INSERT: begin
              if (found) begin
                res_status = STAT_DUPLICATE;
                res_slot   = 1'b1;
                res_idx    = match;
                res_key    = cap_key;
                res_w      = cap_w;
              end else if (count == CNT_W'(SLOTS)) begin
                res_status = STAT_FULL;
              end else begin
                res_slot   = 1'b1;
                res_idx    = IDX_W'(count);
                res_key    = key_r;
                res_w      = wt_r;
                count_next = count + CNT_W'(1);
                used_next  = used + wt_r;
              end
            end
            ACT_ERASE: begin
              if (found) begin
                res_slot   = 1'b1;
                res_idx    = match;
                res_key    = cap_key;
                res_w      = cap_w;
                count_next = count - CNT_W'(1);
                used_next  = used - cap_w;
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            ACT_FIND: begin
              if (found) begin
                res_slot = 1'b1;
                res_idx  = match;
                res_key  = cap_key;
                res_w    = cap_w;
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            default: begin
              res_slot = 1'b1;
              res_idx  = pos_r;
              res_key  = cap_key;
              res_w    = cap_w;
            end
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RST;
      count  <= '0;
      used   <= '0;
      step   <= '0;
      found  <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        budget <= cfg_data;
      end
      done <= (state == ST_DONE);
      if (state == ST_DONE) begin
        count <= count_next;
        used  <= used_next;
      end
      if (accept) begin
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
      if ((state == ST_SCAN) || (state == ST_MOVE)) begin
        step <= (step == LAST_STEP) ? '0 : step + IDX_W'(1);
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= action;
      key_r <= entry_key[KEY_BITS-1:0];
      wt_r  <= entry_weight;
      pos_r <= IDX_W'(position);
      unique case (action)
        ACT_INSERT: begin
          imm        <= no_space;
          imm_status <= STAT_NO_SPACE;
        end
        ACT_ERASE,
        ACT_FIND: begin
          imm        <= 1'b0;
          imm_status <= STAT_OK;
        end
        ACT_READ: begin
          imm        <= !read_ok;
          imm_status <= STAT_OUT_RANGE;
        end
        ACT_CLEAR: begin
          imm        <= 1'b1;
          imm_status <= STAT_OK;
        end
        default: begin
          imm        <= 1'b1;
          imm_status <= STAT_OUT_RANGE;
        end
      endcase
    end
    if (hit) begin
      match <= step;
    end
    if (capture) begin
      cap_key <= head_key;
      cap_w   <= head_weight;
    end
    if (at_last) begin
      last_key <= head_key;
      last_w   <= head_weight;
    end
    if (state == ST_DONE) begin
      status        <= res_status;
      found_index   <= res_slot ? INDEX_W'(res_idx) : '0;
      result_key    <= res_slot ? KEY_W'(res_key) : '0;
      result_weight <= res_slot ? res_w : '0;
      entry_count   <= COUNT_W'(count_next);
      space_used    <= used_next;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a finishing step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count above slot count");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == '0))
    else $error("scan step not rewound");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_move_only_erase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |-> ((op == ACT_ERASE) && found))
    else $error("move pass outside a successful erase");

endmodule

/* rtl/keyed_table_with_space_budget_top.sv */
// Keyed table with a space budget. The entries sit in a ring of SLOTS cells that
// rotates, while a request scans or moves, by one cell per clock past a single key
// compare at its head, so a request that searches or reads the table takes one
// full turn of the ring. Clear, unused action codes, reads out of range and inserts
// that fail the space check finish without a turn: the control goes from idle to
// its done state, which registers done. Insert, find, read and erase of an absent
// key raise done after one scan turn, an erase that finds its key after a second
// turn (it moves the last entry into the freed slot). busy drops in the cycle that
// done is shown, so a new request may start there. done is high for exactly one
// cycle and the receiver cannot hold it off. The space budget register is written
// through cfg_valid, by the user only while the block is idle; it is not enforced.
module keyed_table_with_space_budget_top import kts_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [KEY_W-1:0]    entry_key,
  input  logic [WEIGHT_W-1:0] entry_weight,
  input  logic [POS_W-1:0]    position,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]  found_index,
  output logic [KEY_W-1:0]    result_key,
  output logic [WEIGHT_W-1:0] result_weight,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [BUDGET_W-1:0] space_used
);

  ring_ctrl_t          ring;
  logic [KEY_BITS-1:0] cell_key [SLOTS];
  logic [WEIGHT_W-1:0] cell_w   [SLOTS];
  logic [KEY_BITS-1:0] tail_key;
  logic [WEIGHT_W-1:0] tail_w;

  assign cfg_ready = 1'b1;

  // the head entry wraps to the tail unless a new entry replaces it
  assign tail_key = ring.load ? ring.key[KEY_BITS-1:0] : cell_key[0];
  assign tail_w   = ring.load ? ring.weight : cell_w[0];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      kts_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk        (clk),
        .shift      (ring.shift),
        .din_key    (tail_key),
        .din_weight (tail_w),
        .key        (cell_key[i]),
        .weight     (cell_w[i])
      );
    end else begin : g_body
      kts_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk        (clk),
        .shift      (ring.shift),
        .din_key    (cell_key[i+1]),
        .din_weight (cell_w[i+1]),
        .key        (cell_key[i]),
        .weight     (cell_w[i])
      );
    end
  end

  kts_ctrl #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .entry_key     (entry_key),
    .entry_weight  (entry_weight),
    .position      (position),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .head_key      (cell_key[0]),
    .head_weight   (cell_w[0]),
    .ring          (ring),
    .done          (done),
    .status        (status),
    .found_index   (found_index),
    .result_key    (result_key),
    .result_weight (result_weight),
    .entry_count   (entry_count),
    .space_used    (space_used)
  );

endmodule
